@@ hdl/mtf_pkg.sv @@
`default_nettype none

package mtf_pkg;

  // input beat layout: tuser = func, tdata = key then entry_value
  localparam int KEY_FIELD_W = 8;
  localparam int VAL_FIELD_W = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 1;

  // result beat layout: tuser = status, tdata = found_value
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  localparam logic FUNC_LOOKUP  = 1'b0;
  localparam logic FUNC_INSTALL = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  // commands broadcast from the sequencer to every cell
  typedef struct packed {
    logic wr;    // install into the cell at the fill position
    logic move;  // visited cells take their front neighbor's entry
    logic clr;   // a missed scan forgets which cells it visited
  } mtf_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/move_to_front_lookup_table_unit.sv @@
`default_nettype none

// Move-to-front lookup table: a row of TABLE_DEPTH cells, each holding one key/value
// pair, with a fill count. One item is handled at a time. An install appends at the
// fill position and answers with status full when the table is full. A lookup sends
// a probe down the row one cell per clock; it stops at the cell that hits (front is 0)
// or misses after the last filled cell, and an empty table misses without a probe.
// On a hit, every cell the probe visited takes its front neighbor's entry together
// and the front cell takes the matched pair. The next beat is taken once the result
// sits in the output register; the result waits there until it is taken.
module move_to_front_lookup_table_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 8,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mtf_pkg::IN_TDATA_W-1:0]   in_tdata,   // key[7:0], entry_value[39:8]
  input  wire logic [mtf_pkg::IN_TUSER_W-1:0]   in_tuser,   // func[0]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [mtf_pkg::OUT_TDATA_W-1:0]       out_tdata,  // found_value[31:0]
  output logic [mtf_pkg::OUT_TUSER_W-1:0]       out_tuser   // status[1:0]
);
  import mtf_pkg::*;

  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int KW_EXT   = (KEY_BITS > KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int VW_EXT   = (VALUE_BITS > VAL_FIELD_W) ? VALUE_BITS : VAL_FIELD_W;
  localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_BITS-1:0]    fill_r, fill_nxt;
  logic [KEY_BITS-1:0]    skey_r, skey_nxt;
  logic [VALUE_BITS-1:0]  hval_r, hval_nxt;
  logic [STATUS_W-1:0]    res_st_r, res_st_nxt;
  logic [VAL_FIELD_W-1:0] res_val_r, res_val_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_st_r, out_st_nxt;
  logic [VAL_FIELD_W-1:0] out_val_r, out_val_nxt;

  mtf_ctrl_t              ctrl;
  logic                   start;
  logic                   accept;
  logic                   in_func;
  logic [KW_EXT-1:0]      key_ext;
  logic [VW_EXT-1:0]      wval_ext;
  logic [VW_EXT-1:0]      hit_ext;
  logic [KEY_BITS-1:0]    wr_key;
  logic [VALUE_BITS-1:0]  wr_val;

  logic [KEY_BITS-1:0]    key_chain   [TABLE_DEPTH+1];
  logic [VALUE_BITS-1:0]  val_chain   [TABLE_DEPTH+1];
  logic                   probe_chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] end_vec;
  logic [VALUE_BITS-1:0]  hval_vec    [TABLE_DEPTH];
  logic                   hit_any;
  logic                   end_any;
  logic [VALUE_BITS-1:0]  hit_val_or;

  assign in_func  = in_tuser[0];
  assign key_ext  = KW_EXT'(in_tdata[KEY_FIELD_W-1:0]);
  assign wval_ext = VW_EXT'(in_tdata[KEY_FIELD_W +: VAL_FIELD_W]);
  assign wr_key   = key_ext[KEY_BITS-1:0];
  assign wr_val   = wval_ext[VALUE_BITS-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // the front of the row sees the searched key and its value as its neighbor
  assign key_chain[0]   = skey_r;
  assign val_chain[0]   = hval_r;
  assign probe_chain[0] = start;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mtf_cell #(
      .IDX       (i),
      .CNT_BITS  (CNT_BITS),
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl_i    (ctrl),
      .fill_i    (fill_r),
      .srch_key_i(skey_r),
      .wr_key_i  (wr_key),
      .wr_val_i  (wr_val),
      .prev_key_i(key_chain[i]),
      .prev_val_i(val_chain[i]),
      .probe_i   (probe_chain[i]),
      .key_o     (key_chain[i+1]),
      .val_o     (val_chain[i+1]),
      .probe_o   (probe_chain[i+1]),
      .hit_o     (hit_vec[i]),
      .hit_val_o (hval_vec[i]),
      .end_o     (end_vec[i])
    );
  end

  // at most one cell holds the probe, so a plain or picks its value
  always_comb begin
    hit_val_or = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_val_or = hit_val_or | hval_vec[i];
    end
  end

  assign hit_any = |hit_vec;
  assign end_any = |end_vec;
  assign hit_ext = VW_EXT'(hit_val_or);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    skey_nxt      = skey_r;
    hval_nxt      = hval_r;
    res_st_nxt    = res_st_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_val_nxt   = out_val_r;
    ctrl          = '0;
    start         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_val_nxt = '0;
          state_nxt   = S_FIN;
          if (in_func == FUNC_INSTALL) begin
            if (fill_r == DEPTH_C) begin
              res_st_nxt = STAT_FULL;
            end else begin
              ctrl.wr    = 1'b1;
              fill_nxt   = fill_r + 1'b1;
              res_st_nxt = STAT_OK;
            end
          end else begin
            skey_nxt = wr_key;
            if (fill_r == '0) begin
              res_st_nxt = STAT_MISS;
            end else begin
              start     = 1'b1;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          hval_nxt    = hit_val_or;
          res_st_nxt  = STAT_OK;
          res_val_nxt = hit_ext[VAL_FIELD_W-1:0];
          state_nxt   = S_MOVE;
        end else if (end_any) begin
          ctrl.clr    = 1'b1;
          res_st_nxt  = STAT_MISS;
          res_val_nxt = '0;
          state_nxt   = S_FIN;
        end
      end
      S_MOVE: begin
        ctrl.move = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_val_nxt   = res_val_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    skey_r    <= skey_nxt;
    hval_r    <= hval_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    out_st_r  <= out_st_nxt;
    out_val_r <= out_val_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_st_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("fill count beyond table depth");

  a_probe_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> (hit_vec == '0 && end_vec == '0))
    else $error("probe active outside scan");

  a_hit_end_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(hit_any && end_any) && $onehot0(hit_vec | end_vec))
    else $error("more than one cell reports on the probe");

  a_full_install_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_INSTALL && fill_r == DEPTH_C) |=> $stable(fill_r))
    else $error("install into full table changed fill count");

endmodule

`default_nettype wire

@@ hdl/mtf_cell.sv @@
`default_nettype none

module mtf_cell #(
  parameter int IDX        = 0,
  parameter int CNT_BITS   = 5,
  parameter int KEY_BITS   = 8,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mtf_pkg::mtf_ctrl_t      ctrl_i,
  input  wire logic [CNT_BITS-1:0]     fill_i,
  input  wire logic [KEY_BITS-1:0]     srch_key_i,
  input  wire logic [KEY_BITS-1:0]     wr_key_i,
  input  wire logic [VALUE_BITS-1:0]   wr_val_i,
  input  wire logic [KEY_BITS-1:0]     prev_key_i,
  input  wire logic [VALUE_BITS-1:0]   prev_val_i,
  input  wire logic                    probe_i,
  output logic [KEY_BITS-1:0]          key_o,
  output logic [VALUE_BITS-1:0]        val_o,
  output logic                         probe_o,
  output logic                         hit_o,
  output logic [VALUE_BITS-1:0]        hit_val_o,
  output logic                         end_o
);
  import mtf_pkg::*;

  localparam logic [CNT_BITS-1:0] MY_IDX   = CNT_BITS'(IDX);
  localparam logic [CNT_BITS-1:0] NEXT_IDX = CNT_BITS'(IDX + 1);

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  probe_r;
  logic                  passed_r, passed_nxt;
  logic                  match;
  logic                  last;

  // the probe only ever enters cells below the fill count
  assign match = probe_r && (key_r == srch_key_i);
  assign last  = (fill_i == NEXT_IDX);

  assign hit_o     = match;
  assign hit_val_o = match ? val_r : '0;
  assign end_o     = probe_r && !match && last;
  assign probe_o   = probe_r && !match && !last;
  assign key_o     = key_r;
  assign val_o     = val_r;

  always_comb begin
    key_nxt    = key_r;
    val_nxt    = val_r;
    passed_nxt = passed_r | probe_r;
    if (ctrl_i.move) begin
      passed_nxt = 1'b0;
      if (passed_r) begin
        key_nxt = prev_key_i;
        val_nxt = prev_val_i;
      end
    end else if (ctrl_i.clr) begin
      passed_nxt = 1'b0;
    end else if (ctrl_i.wr && (fill_i == MY_IDX)) begin
      key_nxt = wr_key_i;
      val_nxt = wr_val_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r  <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      probe_r  <= probe_i;
      passed_r <= passed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire
